[rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the SETTINGS frame decoder
// Beat layouts, status codes, setting ids, reset defaults, length check.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned PosW   = 3;
  localparam int unsigned IdW    = 16;
  localparam int unsigned ValAccW = 24;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_BYTE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_VALUE  = 2'd2
  } status_e;

  localparam logic [IdW-1:0] ID_TABLE_SIZE = 16'd1;
  localparam logic [IdW-1:0] ID_PUSH       = 16'd2;
  localparam logic [IdW-1:0] ID_STREAMS    = 16'd3;
  localparam logic [IdW-1:0] ID_WINDOW     = 16'd4;
  localparam logic [IdW-1:0] ID_FRAME_SIZE = 16'd5;
  localparam logic [IdW-1:0] ID_HDR_LIST   = 16'd6;

  localparam logic [PosW-1:0] LAST_ENTRY_POS = 3'd5;

  localparam logic [31:0] PUSH_MAX       = 32'd1;
  localparam logic [31:0] FRAME_SIZE_MIN = 32'd16384;
  localparam logic [31:0] FRAME_SIZE_MAX = 32'd16777215;
  localparam logic [31:0] WINDOW_MAX     = 32'h7fff_ffff;

  localparam logic [31:0] RST_TABLE_SIZE  = 32'd4096;
  localparam logic        RST_PUSH        = 1'b1;
  localparam logic [31:0] RST_STREAMS     = 32'hffff_ffff;
  localparam logic [30:0] RST_WINDOW      = 31'd65535;
  localparam logic [23:0] RST_FRAME_SIZE  = 24'd16384;
  localparam logic [31:0] RST_HEADER_LIST = 32'hffff_ffff;

  typedef struct packed {
    mode_e            mode;
    logic [LenW-1:0]  frame_length;
    logic [7:0]       data_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] hdr_table_size;
    logic        push_enable;
    logic [31:0] stream_limit;
    logic [30:0] window_init;
    logic [23:0] frame_size_limit;
    logic [31:0] hdr_list_limit;
  } out_t;

  typedef struct packed {
    logic [31:0]        table_size;
    logic               push;
    logic [31:0]        streams;
    logic [30:0]        window;
    logic [23:0]        frame_size;
    logic [31:0]        header_list;
    logic [LenW-1:0]    remaining;
    logic [PosW-1:0]    pos;
    logic [IdW-1:0]     id;
    logic [ValAccW-1:0] value;
    status_e            status;
  } state_t;

  // Multiple of six: even, and the nibble digit sum (16 = 1 mod 3) is a
  // multiple of three.
  function automatic logic is_mult6(input logic [LenW-1:0] len);
    logic [6:0] sum;
    logic [4:0] fold;
    sum = '0;
    for (int i = 0; i < LenW / 4; i++) begin
      sum = sum + {3'd0, len[4*i +: 4]};
    end
    fold = {2'd0, sum[6:4]} + {1'b0, sum[3:0]};
    if (fold >= 5'd12) fold = fold - 5'd12;
    if (fold >= 5'd6)  fold = fold - 5'd6;
    if (fold >= 5'd3)  fold = fold - 5'd3;
    return (len[0] == 1'b0) && (fold == 5'd0);
  endfunction

endpackage

[rtl/sfd_step.sv]
// ----------------------------------------------------------------------------
// sfd_step: next-state and result logic for one beat
// Assembles entries, applies and checks settings, decides on a result.
// ----------------------------------------------------------------------------
module sfd_step (
  input  sfd_pkg::in_t    in_i,
  input  sfd_pkg::state_t state_i,
  output sfd_pkg::state_t state_o,
  output sfd_pkg::out_t   result_o,
  output logic            emit_o
);

  logic [31:0] entry_value;
  sfd_pkg::state_t nxt;
  logic emit;

  assign entry_value = {state_i.value, in_i.data_byte};

  always_comb begin
    nxt  = state_i;
    emit = 1'b0;
    unique case (in_i.mode)
      sfd_pkg::MODE_START: begin
        nxt.pos       = '0;
        nxt.id        = '0;
        nxt.value     = '0;
        nxt.remaining = in_i.frame_length;
        if (!sfd_pkg::is_mult6(in_i.frame_length)) begin
          nxt.status = sfd_pkg::ST_BAD_LENGTH;
          emit       = 1'b1;
        end else begin
          nxt.status = sfd_pkg::ST_OK;
          emit       = (in_i.frame_length == '0);
        end
      end
      sfd_pkg::MODE_BYTE: begin
        if (state_i.remaining != '0) begin
          nxt.remaining = state_i.remaining - 1'b1;
          if (state_i.status == sfd_pkg::ST_OK) begin
            unique case (state_i.pos)
              3'd0: nxt.id    = {in_i.data_byte, 8'd0};
              3'd1: nxt.id    = {state_i.id[15:8], in_i.data_byte};
              3'd2: nxt.value = {in_i.data_byte, 16'd0};
              3'd3: nxt.value = {state_i.value[23:16], in_i.data_byte, 8'd0};
              3'd4: nxt.value = {state_i.value[23:8], in_i.data_byte};
              default: begin
                unique case (state_i.id)
                  sfd_pkg::ID_TABLE_SIZE: nxt.table_size = entry_value;
                  sfd_pkg::ID_PUSH: begin
                    if (entry_value > sfd_pkg::PUSH_MAX) nxt.status = sfd_pkg::ST_BAD_VALUE;
                    else nxt.push = entry_value[0];
                  end
                  sfd_pkg::ID_STREAMS: nxt.streams = entry_value;
                  sfd_pkg::ID_WINDOW: begin
                    if (entry_value > sfd_pkg::WINDOW_MAX) nxt.status = sfd_pkg::ST_BAD_VALUE;
                    else nxt.window = entry_value[30:0];
                  end
                  sfd_pkg::ID_FRAME_SIZE: begin
                    if (entry_value < sfd_pkg::FRAME_SIZE_MIN ||
                        entry_value > sfd_pkg::FRAME_SIZE_MAX) begin
                      nxt.status = sfd_pkg::ST_BAD_VALUE;
                    end else begin
                      nxt.frame_size = entry_value[23:0];
                    end
                  end
                  sfd_pkg::ID_HDR_LIST: nxt.header_list = entry_value;
                  default: ;
                endcase
              end
            endcase
            nxt.pos = (state_i.pos >= sfd_pkg::LAST_ENTRY_POS) ? '0 : state_i.pos + 1'b1;
          end
          emit = (nxt.remaining == '0) && (nxt.status != sfd_pkg::ST_BAD_LENGTH);
        end
      end
      default: ;
    endcase
  end

  assign state_o = nxt;
  assign emit_o  = emit;

  assign result_o.status           = nxt.status;
  assign result_o.hdr_table_size   = nxt.table_size;
  assign result_o.push_enable      = nxt.push;
  assign result_o.stream_limit     = nxt.streams;
  assign result_o.window_init      = nxt.window;
  assign result_o.frame_size_limit = nxt.frame_size;
  assign result_o.hdr_list_limit   = nxt.header_list;

endmodule

[rtl/http2_settings_frame_decoder.sv]
// ----------------------------------------------------------------------------
// http2_settings_frame_decoder: HTTP/2 SETTINGS frame payload decoder
// Takes frame-start and payload-byte beats, holds the six settings and
// returns at most one result beat per frame with status and all settings.
// ----------------------------------------------------------------------------
// A beat passes the input register, the step logic, then the result register.
// Throughput: 1 beat per cycle; the input register and the result register
// sit around one pass of single-beat logic, so only a stalled result with
// a new result pending holds the input.
// Reset: asynchronous, active low; settings return to the protocol defaults,
// the parser goes idle with no bytes outstanding, both registers go empty.
module http2_settings_frame_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sfd_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sfd_pkg::out_t   out_data_o
);

  // Input register.
  logic          in_valid_q;
  sfd_pkg::in_t  in_q;

  // Held settings and parser state.
  sfd_pkg::state_t state_q, state_d;

  // Result register.
  logic          out_valid_q;
  sfd_pkg::out_t out_q, result;

  logic emit;
  logic advance;

  sfd_step u_step (
    .in_i     (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result),
    .emit_o   (emit)
  );

  // Advance the held beat unless it makes a result and the result register
  // is full and stalled.
  assign advance    = in_valid_q && (!emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the payload while stalled.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.table_size  <= sfd_pkg::RST_TABLE_SIZE;
      state_q.push        <= sfd_pkg::RST_PUSH;
      state_q.streams     <= sfd_pkg::RST_STREAMS;
      state_q.window      <= sfd_pkg::RST_WINDOW;
      state_q.frame_size  <= sfd_pkg::RST_FRAME_SIZE;
      state_q.header_list <= sfd_pkg::RST_HEADER_LIST;
      state_q.remaining   <= '0;
      state_q.pos         <= '0;
      state_q.id          <= '0;
      state_q.value       <= '0;
      state_q.status      <= sfd_pkg::ST_OK;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Load a new result, or drop the old one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the HTTP/2 SETTINGS frame decoder
// Drives frame-start and payload-byte beats with random idle gaps and random
// result stalls. Decodes every accepted beat in a local model of the six
// settings and checks each result beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ENTRY_BYTES = 6;
  localparam int unsigned TOTAL_BEATS = 1500;
  localparam int unsigned LEN_W       = sfd_pkg::LenW;
  localparam int unsigned ID_W        = sfd_pkg::IdW;

  // One planned beat. Rows marked typed carry a hand-written result that
  // replaces the model's own for that beat.
  typedef struct {
    sfd_pkg::in_t  beat;
    bit            typed;
    sfd_pkg::out_t want;
  } step_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_stall_i = 1'b0;
  sfd_pkg::in_t  in_data_i   = '0;
  logic          in_stall_o;
  logic          out_valid_o;
  sfd_pkg::out_t out_data_o;

  // Model of the decoder; starts at the protocol defaults.
  logic [31:0]              tbl_size   = sfd_pkg::RST_TABLE_SIZE;
  logic                     push_en    = sfd_pkg::RST_PUSH;
  logic [31:0]              stream_lim = sfd_pkg::RST_STREAMS;
  logic [30:0]              win_size   = sfd_pkg::RST_WINDOW;
  logic [23:0]              frm_size   = sfd_pkg::RST_FRAME_SIZE;
  logic [31:0]              hdr_list   = sfd_pkg::RST_HEADER_LIST;
  logic [LEN_W-1:0]         left_bytes = '0;
  logic [sfd_pkg::PosW-1:0] entry_pos  = '0;
  logic [ID_W-1:0]          id_acc     = '0;
  logic [23:0]              val_acc    = '0;
  sfd_pkg::status_e         frm_status = sfd_pkg::ST_OK;

  sfd_pkg::out_t due_settings[$];
  step_t         plan_q[$];
  int unsigned   beats_sent = 0;
  int unsigned   mismatches = 0;
  int unsigned   stall_left = 0;
  bit            quiet      = 1'b0;
  bit            drain_req  = 1'b0;
  bit            drain_done = 1'b0;

  // Values that sit on or next to the legal bounds of the settings.
  logic [31:0] corner_vals [10] = '{32'd0, 32'd1, sfd_pkg::PUSH_MAX + 1,
                                    sfd_pkg::FRAME_SIZE_MIN - 1, sfd_pkg::FRAME_SIZE_MIN,
                                    sfd_pkg::FRAME_SIZE_MAX, sfd_pkg::FRAME_SIZE_MAX + 1,
                                    sfd_pkg::WINDOW_MAX, sfd_pkg::WINDOW_MAX + 1,
                                    32'hffff_ffff};

  http2_settings_frame_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Unused fields of a beat get random bits so every input bit toggles.
  function automatic sfd_pkg::in_t start_beat(input logic [LEN_W-1:0] len);
    sfd_pkg::in_t b;
    b.mode         = sfd_pkg::MODE_START;
    b.frame_length = len;
    b.data_byte    = 8'($urandom);
    return b;
  endfunction

  function automatic sfd_pkg::in_t byte_beat(input logic [7:0] data);
    sfd_pkg::in_t b;
    b.mode         = sfd_pkg::MODE_BYTE;
    b.frame_length = LEN_W'($urandom);
    b.data_byte    = data;
    return b;
  endfunction

  task automatic plan_beat(input sfd_pkg::in_t beat, input bit typed = 1'b0,
                           input sfd_pkg::out_t want = '0);
    step_t s;
    s.beat  = beat;
    s.typed = typed;
    s.want  = want;
    plan_q  = {plan_q, s};
  endtask

  // Queue one setting entry: 16-bit id then 32-bit value, both big-endian.
  task automatic plan_entry(input logic [ID_W-1:0] id, input logic [31:0] value);
    plan_beat(byte_beat(id[15:8]));
    plan_beat(byte_beat(id[7:0]));
    plan_beat(byte_beat(value[31:24]));
    plan_beat(byte_beat(value[23:16]));
    plan_beat(byte_beat(value[15:8]));
    plan_beat(byte_beat(value[7:0]));
  endtask

  // Mostly known ids with a mix of corner, random and legal values; the rest
  // are unknown ids that the decoder has to skip.
  task automatic plan_random_entry();
    logic [ID_W-1:0] id;
    logic [31:0]     value;
    if ($urandom_range(0, 9) < 8) begin
      id = ID_W'($urandom_range(sfd_pkg::ID_TABLE_SIZE, sfd_pkg::ID_HDR_LIST));
    end else begin
      id = ID_W'($urandom);
    end
    case ($urandom_range(0, 3))
      0: value = corner_vals[$urandom_range(0, 9)];
      1: value = $urandom;
      default: begin
        case (id)
          sfd_pkg::ID_PUSH:   value = $urandom_range(0, 1);
          sfd_pkg::ID_WINDOW: value = $urandom & sfd_pkg::WINDOW_MAX;
          sfd_pkg::ID_FRAME_SIZE: begin
            value = $urandom_range(sfd_pkg::FRAME_SIZE_MIN, sfd_pkg::FRAME_SIZE_MAX);
          end
          default: value = $urandom;
        endcase
      end
    endcase
    plan_entry(id, value);
  endtask

  // Decode one accepted beat; hand back the result beat it causes, if any.
  task automatic decode_beat(input sfd_pkg::in_t beat, output bit has_res,
                             output sfd_pkg::out_t res);
    logic [31:0] value;
    has_res = 1'b0;
    res     = '0;
    if (beat.mode == sfd_pkg::MODE_START) begin
      // A new start drops whatever frame is still open.
      entry_pos  = '0;
      id_acc     = '0;
      val_acc    = '0;
      left_bytes = beat.frame_length;
      if (beat.frame_length % ENTRY_BYTES != 0) begin
        frm_status = sfd_pkg::ST_BAD_LENGTH;
        has_res    = 1'b1;
      end else begin
        frm_status = sfd_pkg::ST_OK;
        has_res    = (beat.frame_length == 0);
      end
    end else if (left_bytes != 0) begin
      left_bytes = left_bytes - 1'b1;
      // After a bad length or a bad value, only count the bytes down.
      if (frm_status == sfd_pkg::ST_OK) begin
        case (entry_pos)
          3'd0: id_acc = {beat.data_byte, 8'h00};
          3'd1: id_acc[7:0] = beat.data_byte;
          3'd2: val_acc = {beat.data_byte, 16'h0000};
          3'd3: val_acc[15:8] = beat.data_byte;
          3'd4: val_acc[7:0] = beat.data_byte;
          default: begin
            value = {val_acc, beat.data_byte};
            case (id_acc)
              sfd_pkg::ID_TABLE_SIZE: tbl_size = value;
              sfd_pkg::ID_PUSH: begin
                if (value > sfd_pkg::PUSH_MAX) frm_status = sfd_pkg::ST_BAD_VALUE;
                else push_en = value[0];
              end
              sfd_pkg::ID_STREAMS: stream_lim = value;
              sfd_pkg::ID_WINDOW: begin
                if (value > sfd_pkg::WINDOW_MAX) frm_status = sfd_pkg::ST_BAD_VALUE;
                else win_size = value[30:0];
              end
              sfd_pkg::ID_FRAME_SIZE: begin
                if (value < sfd_pkg::FRAME_SIZE_MIN || value > sfd_pkg::FRAME_SIZE_MAX) begin
                  frm_status = sfd_pkg::ST_BAD_VALUE;
                end else begin
                  frm_size = value[23:0];
                end
              end
              sfd_pkg::ID_HDR_LIST: hdr_list = value;
              default: ;
            endcase
          end
        endcase
        entry_pos = (entry_pos >= sfd_pkg::LAST_ENTRY_POS) ? '0 : entry_pos + 1'b1;
      end
      has_res = (left_bytes == 0) && (frm_status != sfd_pkg::ST_BAD_LENGTH);
    end
    if (has_res) begin
      res.status           = frm_status;
      res.hdr_table_size   = tbl_size;
      res.push_enable      = push_en;
      res.stream_limit     = stream_lim;
      res.window_init      = win_size;
      res.frame_size_limit = frm_size;
      res.hdr_list_limit   = hdr_list;
    end
  endtask

  // Hold the beat until it is taken, decode it, then idle for a random gap, which may be empty.
  task automatic send_beat(input step_t s);
    bit            has_res;
    sfd_pkg::out_t res;
    sfd_pkg::out_t due;
    int unsigned   gap;
    in_valid_i <= 1'b1;
    in_data_i  <= s.beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    decode_beat(s.beat, has_res, res);
    if (has_res) begin
      due          = s.typed ? s.want : res;
      due_settings = {due_settings, due};
    end
    beats_sent++;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0 || drain_req) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_req) begin
        // Hold off until every outstanding result beat has come back.
        @(posedge clk_i);
        while (due_settings.size() != 0) @(posedge clk_i);
        drain_req = 1'b0;
      end
    end
  endtask

  task automatic run_plan();
    foreach (plan_q[i]) send_beat(plan_q[i]);
    plan_q.delete();
  endtask

  task automatic compare(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input sfd_pkg::out_t got);
    sfd_pkg::out_t want;
    if (due_settings.size() == 0) begin
      $error("status: expected no result beat, got 0x%0h", got.status);
      mismatches++;
      return;
    end
    want = due_settings.pop_front();
    compare("status", 32'(want.status), 32'(got.status));
    compare("hdr_table_size", want.hdr_table_size, got.hdr_table_size);
    compare("push_enable", 32'(want.push_enable), 32'(got.push_enable));
    compare("stream_limit", want.stream_limit, got.stream_limit);
    compare("window_init", 32'(want.window_init), 32'(got.window_init));
    compare("frame_size_limit", 32'(want.frame_size_limit), 32'(got.frame_size_limit));
    compare("hdr_list_limit", want.hdr_list_limit, got.hdr_list_limit);
  endtask

  // Result side: check each taken beat, and stall in random bursts unless
  // the current stretch runs quiet.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sfd_pkg::out_t dflt;
    sfd_pkg::out_t bad_len;
    sfd_pkg::out_t last_want;
    int unsigned   kind;
    int unsigned   n;
    int unsigned   len;

    dflt = '{sfd_pkg::ST_OK, sfd_pkg::RST_TABLE_SIZE, sfd_pkg::RST_PUSH,
             sfd_pkg::RST_STREAMS, sfd_pkg::RST_WINDOW, sfd_pkg::RST_FRAME_SIZE,
             sfd_pkg::RST_HEADER_LIST};
    bad_len                    = dflt;
    bad_len.status             = sfd_pkg::ST_BAD_LENGTH;
    last_want                  = dflt;
    last_want.status           = sfd_pkg::ST_BAD_VALUE;
    last_want.push_enable      = 1'b0;
    last_want.frame_size_limit = 24'hff_ffff;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty and rejected frames at the defaults, swallowed and
    // stray bytes, the longest length, a frame dropped by a new start after
    // two applied entries, then a window size one past its limit.
    plan_beat(start_beat(24'd0), 1'b1, dflt);
    plan_beat(start_beat(24'd1), 1'b1, bad_len);
    plan_beat(byte_beat(8'hff));
    plan_beat(byte_beat(8'h00));
    plan_beat(start_beat(24'hff_ffff), 1'b1, bad_len);
    plan_beat(start_beat(24'd18));
    plan_entry(sfd_pkg::ID_PUSH, 32'd0);
    plan_entry(sfd_pkg::ID_FRAME_SIZE, sfd_pkg::FRAME_SIZE_MAX);
    plan_beat(start_beat(24'd6));
    plan_entry(sfd_pkg::ID_WINDOW, sfd_pkg::WINDOW_MAX + 1);
    plan_q[plan_q.size() - 1].typed = 1'b1;
    plan_q[plan_q.size() - 1].want  = last_want;
    run_plan();

    // Random: mostly well-formed frames, the rest broken or noise.
    while (beats_sent < TOTAL_BEATS) begin
      quiet = ($urandom_range(0, 7) == 0);
      if (!drain_done && beats_sent > TOTAL_BEATS / 2) begin
        drain_req  = 1'b1;
        drain_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        plan_beat(start_beat(LEN_W'(n * ENTRY_BYTES)));
        repeat (n) plan_random_entry();
      end else if (kind < 78) begin
        // Bad length; send part of it, or run past its end into stray bytes.
        len = ENTRY_BYTES * $urandom_range(0, 5) + $urandom_range(1, 5);
        plan_beat(start_beat(LEN_W'(len)));
        repeat ($urandom_range(0, len + 2)) plan_beat(byte_beat(8'($urandom)));
      end else if (kind < 88) begin
        // Cut the frame short; the next start drops it.
        n = $urandom_range(1, 4);
        plan_beat(start_beat(LEN_W'(n * ENTRY_BYTES)));
        repeat (n - 1) plan_random_entry();
        repeat ($urandom_range(1, 5)) plan_beat(byte_beat(8'($urandom)));
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 3)) plan_beat(byte_beat(8'($urandom)));
      end else begin
        plan_beat(start_beat(LEN_W'($urandom)));
        repeat ($urandom_range(0, 12)) plan_beat(byte_beat(8'($urandom)));
      end
      run_plan();
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give a late or extra result beat time to show up.
    @(posedge clk_i);
    while (due_settings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
